[rtl/cleb_pkg.sv]
package cleb_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int CNT_W        = 7;
    localparam int CMDQ_DEPTH   = 2;
    localparam int CMDQ_PW      = $clog2(CMDQ_DEPTH);

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_LEFT   = 3'd1;
    localparam logic [2:0] OP_RIGHT  = 3'd2;
    localparam logic [2:0] OP_BKSP   = 3'd3;
    localparam logic [2:0] OP_DUMP   = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NOEFF = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        K_INSERT,
        K_LEFT,
        K_RIGHT,
        K_BKSP,
        K_DUMP,
        K_BAD
    } t_kind;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] char_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       char_out;
        logic             is_last;
        logic [1:0]       status;
        logic [CNT_W-1:0] cursor_pos;
        logic [CNT_W-1:0] text_length;
    } t_out_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
    } t_cmd;

endpackage

[rtl/cleb_front.sv]
module cleb_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  cleb_pkg::t_in_item i_in_item,
    output logic               o_cmd_valid,
    output cleb_pkg::t_cmd     o_cmd,
    input  logic               i_cmd_take
);

    cleb_pkg::t_cmd                  r_q [cleb_pkg::CMDQ_DEPTH];
    logic [cleb_pkg::CMDQ_PW-1:0]    r_wr_ptr;
    logic [cleb_pkg::CMDQ_PW-1:0]    r_rd_ptr;
    logic [cleb_pkg::CMDQ_PW:0]      r_count;
    logic [cleb_pkg::CMDQ_PW:0]      n_count;
    cleb_pkg::t_cmd                  dec_cmd;
    logic                            push_ok;
    logic                            take_ok;

    always_comb begin
        dec_cmd.ch = i_in_item.char_in;
        unique case (i_in_item.operation)
            cleb_pkg::OP_INSERT: dec_cmd.kind = cleb_pkg::K_INSERT;
            cleb_pkg::OP_LEFT:   dec_cmd.kind = cleb_pkg::K_LEFT;
            cleb_pkg::OP_RIGHT:  dec_cmd.kind = cleb_pkg::K_RIGHT;
            cleb_pkg::OP_BKSP:   dec_cmd.kind = cleb_pkg::K_BKSP;
            cleb_pkg::OP_DUMP:   dec_cmd.kind = cleb_pkg::K_DUMP;
            default:             dec_cmd.kind = cleb_pkg::K_BAD;
        endcase
    end

    assign full        = (r_count == (cleb_pkg::CMDQ_PW+1)'(cleb_pkg::CMDQ_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push_ok     = push && !full;
    assign take_ok     = i_cmd_take && o_cmd_valid;

    always_comb begin
        n_count = r_count;
        if (push_ok && !take_ok) begin
            n_count = r_count + 1'b1;
        end else if (!push_ok && take_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (take_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_ptr] <= dec_cmd;
        end
    end

endmodule

[rtl/cleb_exec.sv]
module cleb_exec #(
    parameter int CAPACITY = cleb_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  cleb_pkg::t_cmd      i_cmd,
    output logic                o_cmd_take,
    output logic                empty,
    input  logic                pop,
    output cleb_pkg::t_out_item o_out_item
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = cleb_pkg::CNT_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MOVE_L = 4'b0010,
        S_MOVE_R = 4'b0100,
        S_DUMP   = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_left, n_left;
    logic [CW-1:0]       r_right, n_right;
    logic [CW-1:0]       r_k, n_k;
    logic [7:0]          r_mem [CAPACITY];
    logic [7:0]          r_rd_data;
    logic                r_out_valid;
    cleb_pkg::t_out_item r_out;

    logic                out_free;
    logic [CW-1:0]       total;
    logic                we, re, emit;
    logic [CW-1:0]       wa_full, ra_full;
    logic [7:0]          wdata;
    cleb_pkg::t_out_item e_item;

    function automatic logic [CW-1:0] dump_addr(input logic [CW-1:0] k,
                                                input logic [CW-1:0] left,
                                                input logic [CW-1:0] right);
        logic [CW-1:0] a;
        if (k < left) begin
            a = k;
        end else begin
            a = k - left - right + CAP_C;
        end
        return a;
    endfunction

    assign out_free   = !r_out_valid || pop;
    assign total      = r_left + r_right;
    assign empty      = !r_out_valid;
    assign o_out_item = r_out;

    always_comb begin
        n_state    = r_state;
        n_left     = r_left;
        n_right    = r_right;
        n_k        = r_k;
        o_cmd_take = 1'b0;
        we         = 1'b0;
        re         = 1'b0;
        wa_full    = r_left;
        ra_full    = r_k;
        wdata      = r_rd_data;
        emit       = 1'b0;
        e_item     = '0;
        e_item.is_last = 1'b1;
        e_item.status  = cleb_pkg::ST_DONE;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_take = 1'b1;
                    emit       = 1'b1;
                    case (i_cmd.kind)
                        cleb_pkg::K_INSERT: begin
                            if ({1'b0, total} < (CW+1)'(CAPACITY)) begin
                                we      = 1'b1;
                                wa_full = r_left;
                                wdata   = i_cmd.ch;
                                n_left  = r_left + 1'b1;
                            end else begin
                                e_item.status = cleb_pkg::ST_FULL;
                            end
                        end
                        cleb_pkg::K_LEFT: begin
                            if (r_left != '0) begin
                                emit    = 1'b0;
                                re      = 1'b1;
                                ra_full = r_left - 1'b1;
                                n_state = S_MOVE_L;
                            end else begin
                                e_item.status = cleb_pkg::ST_NOEFF;
                            end
                        end
                        cleb_pkg::K_RIGHT: begin
                            if (r_right != '0) begin
                                emit    = 1'b0;
                                re      = 1'b1;
                                ra_full = CAP_C - r_right;
                                n_state = S_MOVE_R;
                            end else begin
                                e_item.status = cleb_pkg::ST_NOEFF;
                            end
                        end
                        cleb_pkg::K_BKSP: begin
                            if (r_left != '0) begin
                                n_left = r_left - 1'b1;
                            end else begin
                                e_item.status = cleb_pkg::ST_NOEFF;
                            end
                        end
                        cleb_pkg::K_DUMP: begin
                            if (total != '0) begin
                                emit    = 1'b0;
                                re      = 1'b1;
                                n_k     = '0;
                                ra_full = dump_addr('0, r_left, r_right);
                                n_state = S_DUMP;
                            end else begin
                                e_item.status = cleb_pkg::ST_NOEFF;
                            end
                        end
                        default: begin
                            e_item.status = cleb_pkg::ST_NOEFF;
                        end
                    endcase
                end
            end
            S_MOVE_L: begin
                if (out_free) begin
                    we      = 1'b1;
                    wa_full = CAP_C - 1'b1 - r_right;
                    n_left  = r_left - 1'b1;
                    n_right = r_right + 1'b1;
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MOVE_R: begin
                if (out_free) begin
                    we      = 1'b1;
                    wa_full = r_left;
                    n_left  = r_left + 1'b1;
                    n_right = r_right - 1'b1;
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    emit            = 1'b1;
                    e_item.char_out = r_rd_data;
                    e_item.is_last  = ((r_k + 1'b1) == total);
                    if ((r_k + 1'b1) == total) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        re      = 1'b1;
                        ra_full = dump_addr(r_k + 1'b1, r_left, r_right);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        e_item.cursor_pos  = n_left;
        e_item.text_length = n_left + n_right;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left      <= '0;
            r_right     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_right <= n_right;
            r_k     <= n_k;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= e_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa_full[AW-1:0]] <= wdata;
        end
        if (re) begin
            r_rd_data <= r_mem[ra_full[AW-1:0]];
        end
    end

endmodule

[rtl/cursor_line_edit_buffer.sv]
// Gap-buffer line editor. Commands enter through a two-entry command queue
// and results leave through a single result register, so commands can be
// queued while a result waits. Insert, backspace, boundary no-ops and invalid
// codes complete in the idle state. Cursor left and right pass through a move
// state: the text store has one read and one write port with a registered
// read, so the moved character is read in the idle state and written to the
// other stack in the move state. A dump starts the first read in the idle
// state and then gives one character per cycle while pop keeps up. The store
// needs no clearing after reset; only written entries are ever read.
module cursor_line_edit_buffer #(
    parameter int CAPACITY = cleb_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  cleb_pkg::t_in_item  i_in_item,
    output logic                empty,
    input  logic                pop,
    output cleb_pkg::t_out_item o_out_item
);

    localparam logic [cleb_pkg::CNT_W-1:0] CAP_C = cleb_pkg::CNT_W'(CAPACITY);

    logic           cmd_valid;
    logic           cmd_take;
    cleb_pkg::t_cmd cmd;

    cleb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    cleb_exec #(
        .CAPACITY (CAPACITY)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item)
    );

    a_cursor_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out_item.cursor_pos <= o_out_item.text_length))
        else $error("cursor beyond text length");

    a_len_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out_item.text_length <= CAP_C))
        else $error("text length above capacity");

    a_full_only_at_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.status == cleb_pkg::ST_FULL)
            |-> (o_out_item.text_length == CAP_C))
        else $error("full status below capacity");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

endmodule
